// ===== rtl/core/mbrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read holding registers responder: shared definitions
// Constants, microcode control word, CRC step and the microprogram table.
// ----------------------------------------------------------------------------
package mbrh_pkg;

  localparam logic [6:0]  MAX_COUNT   = 7'd125;
  localparam logic [7:0]  EXC_BIT     = 8'h80;
  localparam logic [7:0]  EXC_ADDRESS = 8'd2;
  localparam logic [7:0]  EXC_VALUE   = 8'd3;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [1:0] PART_HDR  = 2'd0;
  localparam logic [1:0] PART_DATA = 2'd1;
  localparam logic [1:0] PART_CRC  = 2'd2;

  localparam logic CFG_IDX_SLAVE_ADDR = 1'b0;

  localparam logic [2:0] CRC_NONE = 3'd0;
  localparam logic [2:0] CRC_H0   = 3'd1;
  localparam logic [2:0] CRC_H1   = 3'd2;
  localparam logic [2:0] CRC_H2   = 3'd3;
  localparam logic [2:0] CRC_DHI  = 3'd4;
  localparam logic [2:0] CRC_DLO  = 3'd5;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_HDR  = 2'd1;
  localparam logic [1:0] EMIT_DATA = 2'd2;
  localparam logic [1:0] EMIT_CRC  = 2'd3;

  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_NO_REQ = 3'd2;
  localparam logic [2:0] COND_EXC    = 3'd3;
  localparam logic [2:0] COND_MORE   = 3'd4;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SETUP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CRC0  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CRC1  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CRC2  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_HDR   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_FETCH = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DATA  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_TRAIL = 4'd8;

  typedef struct packed {
    logic              wait_in;
    logic              setup;
    logic [2:0]        crc_sel;
    logic [1:0]        emit;
    logic              fetch;
    logic              dec;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_req;
    logic exc;
    logic more;
    logic space;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_NO_REQ;
        w.target  = STEP_IDLE;
      end
      STEP_SETUP: begin
        w.setup = 1'b1;
      end
      STEP_CRC0: begin
        w.crc_sel = CRC_H0;
      end
      STEP_CRC1: begin
        w.crc_sel = CRC_H1;
      end
      STEP_CRC2: begin
        w.crc_sel = CRC_H2;
      end
      STEP_HDR: begin
        w.emit   = EMIT_HDR;
        w.cond   = COND_EXC;
        w.target = STEP_TRAIL;
      end
      STEP_FETCH: begin
        w.crc_sel = CRC_DHI;
        w.fetch   = 1'b1;
      end
      STEP_DATA: begin
        w.crc_sel = CRC_DLO;
        w.emit    = EMIT_DATA;
        w.dec     = 1'b1;
        w.cond    = COND_MORE;
        w.target  = STEP_FETCH;
      end
      STEP_TRAIL: begin
        w.emit   = EMIT_CRC;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mbrh_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one load or read request word.
// ----------------------------------------------------------------------------
interface mbrh_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  request_id;
  logic [7:0]  func_code;
  logic [15:0] start_address;
  logic [15:0] register_count;
  logic [5:0]  load_index;
  logic [15:0] load_value;

  modport source (
    output valid, req_type, request_id, func_code, start_address,
           register_count, load_index, load_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, request_id, func_code, start_address,
           register_count, load_index, load_value,
    output ready
  );
endinterface

// ===== rtl/core/mbrh_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one frame part word.
// ----------------------------------------------------------------------------
interface mbrh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_part;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;
  logic       last;

  modport source (
    output valid, frame_part, byte_a, byte_b, byte_c, last,
    input  ready
  );

  modport sink (
    input  valid, frame_part, byte_a, byte_b, byte_c, last,
    output ready
  );
endinterface

// ===== rtl/core/mbrh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mbrh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 50,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mbrh_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holding register store
// RAM plus per-entry valid bits so that unwritten registers read as zero.
// ----------------------------------------------------------------------------
module mbrh_store #(
  parameter int REG_DEPTH = 50,
  localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [REG_DEPTH-1:0] valid_r;
  logic                 hit_r;
  logic [15:0]          q;
  logic                 in_range;

  mbrh_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_range),
    .raddr (raddr),
    .rdata (q)
  );

  assign in_range = ({1'b0, raddr} < (AW + 1)'(REG_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      hit_r <= in_range && valid_r[raddr];
    end
  end

  assign rdata = hit_r ? q : 16'h0000;

endmodule

// ===== rtl/core/mbrh_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the microprogram with conditional jumps and output stall.
// ----------------------------------------------------------------------------
module mbrh_seq
  import mbrh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  status_t   status,
  output ctl_word_t ctl,
  output logic      ready
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ctl_word_t         word;
  logic              stall;
  logic              take;

  assign word  = ucode(step_r);
  assign stall = (word.emit != EMIT_NONE) && !status.space;
  assign ready = word.wait_in;

  always_comb begin
    case (word.cond)
      COND_NEVER:  take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_NO_REQ: take = !status.in_req;
      COND_EXC:    take = status.exc;
      COND_MORE:   take = status.more;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign ctl = stall ? '0 : word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/mbrh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response datapath
// Request checks, header bytes, CRC unit, address walk and output register.
// ----------------------------------------------------------------------------
module mbrh_dp
  import mbrh_pkg::*;
#(
  parameter int REG_DEPTH = 50,
  localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_word_t         ctl,
  input  logic              accept,
  input  logic [7:0]        request_id,
  input  logic [7:0]        func_code,
  input  logic [15:0]       start_address,
  input  logic [15:0]       register_count,
  input  logic [7:0]        slave_address,
  input  logic [15:0]       rd_data,
  output logic [AW-1:0]     rd_addr,
  output status_t           status,
  mbrh_out_if.source        out_ch
);

  logic [7:0]    id_r;
  logic [7:0]    fc_r;
  logic [15:0]   start_r;
  logic [15:0]   count_r;
  logic [7:0]    hdr_a_r;
  logic [7:0]    hdr_b_r;
  logic [7:0]    hdr_c_r;
  logic          exc_r;
  logic [15:0]   crc_r;
  logic [15:0]   d_r;
  logic [AW-1:0] addr_r;
  logic [6:0]    cnt_r;
  logic          out_valid_r;
  logic [1:0]    out_part_r;
  logic [7:0]    out_a_r;
  logic [7:0]    out_b_r;
  logic [7:0]    out_c_r;
  logic          out_last_r;
  logic          cnt_bad;
  logic          adr_bad;
  logic [7:0]    crc_in;

  assign cnt_bad = (count_r == 16'd0) || (count_r > {9'd0, MAX_COUNT});
  assign adr_bad = ({1'b0, start_r} + {1'b0, count_r}) > 17'(REG_DEPTH);

  always_comb begin
    case (ctl.crc_sel)
      CRC_H0:  crc_in = hdr_a_r;
      CRC_H1:  crc_in = hdr_b_r;
      CRC_H2:  crc_in = hdr_c_r;
      CRC_DHI: crc_in = rd_data[15:8];
      CRC_DLO: crc_in = d_r[7:0];
      default: crc_in = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r    <= request_id;
      fc_r    <= func_code;
      start_r <= start_address;
      count_r <= register_count;
    end
    if (ctl.setup) begin
      if (cnt_bad || adr_bad) begin
        hdr_a_r <= id_r;
        hdr_b_r <= fc_r | EXC_BIT;
        hdr_c_r <= cnt_bad ? EXC_VALUE : EXC_ADDRESS;
      end else begin
        hdr_a_r <= slave_address;
        hdr_b_r <= fc_r;
        hdr_c_r <= {count_r[6:0], 1'b0};
      end
      addr_r <= start_r[AW-1:0];
      cnt_r  <= count_r[6:0];
    end
    if (ctl.setup) begin
      crc_r <= CRC_INIT;
    end else if (ctl.crc_sel != CRC_NONE) begin
      crc_r <= crc_byte(crc_r, crc_in);
    end
    if (ctl.fetch) begin
      d_r    <= rd_data;
      addr_r <= addr_r + 1'b1;
    end
    if (ctl.dec) begin
      cnt_r <= cnt_r - 1'b1;
    end
    case (ctl.emit)
      EMIT_HDR: begin
        out_part_r <= PART_HDR;
        out_a_r    <= hdr_a_r;
        out_b_r    <= hdr_b_r;
        out_c_r    <= hdr_c_r;
        out_last_r <= 1'b0;
      end
      EMIT_DATA: begin
        out_part_r <= PART_DATA;
        out_a_r    <= d_r[15:8];
        out_b_r    <= d_r[7:0];
        out_c_r    <= 8'h00;
        out_last_r <= 1'b0;
      end
      EMIT_CRC: begin
        out_part_r <= PART_CRC;
        out_a_r    <= crc_r[7:0];
        out_b_r    <= crc_r[15:8];
        out_c_r    <= 8'h00;
        out_last_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.setup) begin
        exc_r <= cnt_bad || adr_bad;
      end
      if (ctl.emit != EMIT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign rd_addr = addr_r;

  assign status.in_req = 1'b0;
  assign status.exc    = exc_r;
  assign status.more   = (cnt_r != 7'd1);
  assign status.space  = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_part = out_part_r;
  assign out_ch.byte_a     = out_a_r;
  assign out_ch.byte_b     = out_b_r;
  assign out_ch.byte_c     = out_c_r;
  assign out_ch.last       = out_last_r;

endmodule

// ===== rtl/core/modbus_read_holding_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read holding registers responder
// While idle a load word is taken every cycle and writes its register at once.
// A read request runs the setup and CRC0 to CRC2 steps, then emits its header
// word; each register takes a fetch and a data step, the latter emitting its data
// word, as the CRC unit takes one byte a cycle while the output does not stall;
// the trailer then emits the CRC word and the next request is taken; an exception
// skips to the trailer. Reset clears all registers and sets the address to 1.
// ----------------------------------------------------------------------------
module modbus_read_holding_responder
  import mbrh_pkg::*;
#(
  parameter int REG_DEPTH = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  mbrh_in_if.sink     in_ch,
  mbrh_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;

  logic [7:0]    slave_address_r;
  logic          cfg_write;
  ctl_word_t     ctl;
  status_t       dp_status;
  status_t       status;
  logic          ready;
  logic          accept;
  logic          load_we;
  logic [15:0]   rd_data;
  logic [AW-1:0] rd_addr;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_SLAVE_ADDR) ? {24'd0, slave_address_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
    end else if (cfg_write && (cfg_paddr[2] == CFG_IDX_SLAVE_ADDR)) begin
      slave_address_r <= cfg_pwdata[7:0];
    end
  end

  assign in_ch.ready = ready;
  assign accept      = in_ch.valid && ready;
  assign load_we     = accept && !in_ch.req_type &&
                       ({1'b0, in_ch.load_index} < 7'(REG_DEPTH));

  assign status.in_req = in_ch.valid && in_ch.req_type;
  assign status.exc    = dp_status.exc;
  assign status.more   = dp_status.more;
  assign status.space  = dp_status.space;

  mbrh_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl),
    .ready  (ready)
  );

  mbrh_store #(.REG_DEPTH(REG_DEPTH)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (load_we),
    .waddr (in_ch.load_index[AW-1:0]),
    .wdata (in_ch.load_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mbrh_dp #(.REG_DEPTH(REG_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .accept         (accept),
    .request_id     (in_ch.request_id),
    .func_code      (in_ch.func_code),
    .start_address  (in_ch.start_address),
    .register_count (in_ch.register_count),
    .slave_address  (slave_address_r),
    .rd_data        (rd_data),
    .rd_addr        (rd_addr),
    .status         (dp_status),
    .out_ch         (out_ch)
  );

endmodule
